FILE: src/i2cm_seq_pkg.sv
package i2cm_seq_pkg;

  // Write buffer depth and the widths that follow from it
  localparam int BUFFER_DEPTH = 32;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_EVENT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    BUS_NONE      = 3'd0,
    BUS_START     = 3'd1,
    BUS_TRANSMIT  = 3'd2,
    BUS_RESTART   = 3'd3,
    BUS_RX_ENABLE = 3'd4,
    BUS_ACK       = 3'd5,
    BUS_NACK_STOP = 3'd6,
    BUS_STOP      = 3'd7
  } bus_cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_W_ADDR    = 4'd1,
    PH_W_CMD     = 4'd2,
    PH_W_DATA    = 4'd3,
    PH_R_ADDR    = 4'd4,
    PH_R_REG     = 4'd5,
    PH_R_RESTART = 4'd6,
    PH_R_ADDR_RD = 4'd7,
    PH_R_ENABLE  = 4'd8,
    PH_R_WAIT    = 4'd9
  } phase_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] slave_byte;
    logic [7:0] command_byte;
    logic [7:0] payload_byte;
    logic [5:0] byte_count;
    logic       transmit_busy;
    logic       receive_full;
    logic [7:0] received_byte;
  } in_word_t;

  typedef struct packed {
    bus_cmd_t   bus_command;
    logic [7:0] transmit_byte;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       request_ignored;
    logic       busy_res;
  } out_word_t;

endpackage

FILE: src/i2c_master_transaction_sequencer.sv
// Channel | Ports                            | Word
// input   | in_valid, in_ready, in_word      | in_word_t: request or engine event
// output  | out_valid, out_ready, out_word   | out_word_t: bus command, read byte
//
// One word in per cycle while in_ready is high; its result is in the output register in the next cycle.
// The write buffer is a synchronous RAM whose read port always points at the
// next send position, so the byte is ready before the data event arrives.
// in_ready drops only while a result is held and out_ready is low.
// Reset (rst_n, synchronous) puts the sequencer idle with an empty buffer;
// buffer contents are not cleared.
module i2c_master_transaction_sequencer
  import i2cm_seq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] payload_fill_r, payload_fill_nxt;
  logic [CNT_W-1:0] send_position_r, send_position_nxt;
  logic [CNT_W-1:0] write_total_r, write_total_nxt;
  logic [CNT_W-1:0] read_total_r, read_total_nxt;
  logic [CNT_W-1:0] read_position_r, read_position_nxt;
  logic [7:0]       target_address_r, target_address_nxt;
  logic [7:0]       target_command_r, target_command_nxt;

  logic             out_valid_r;
  out_word_t        out_word_r;
  out_word_t        res;

  logic             in_accept;
  logic [5:0]       read_count;

  // Write buffer RAM
  logic [7:0]       payload_mem [BUFFER_DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  logic [7:0]       mem_rdata_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign mem_waddr  = payload_fill_r[IDX_W-1:0];
  assign mem_raddr  = send_position_nxt[IDX_W-1:0];
  assign read_count = (in_word.byte_count == 6'd0) ? 6'd1 : in_word.byte_count;

  // RAM: one write, one registered read with same-address forwarding
  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_mem[mem_waddr] <= in_word.payload_byte;
    end
    if (mem_we && (mem_waddr == mem_raddr)) begin
      mem_rdata_r <= in_word.payload_byte;
    end else begin
      mem_rdata_r <= payload_mem[mem_raddr];
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      payload_fill_r   <= '0;
      send_position_r  <= '0;
      write_total_r    <= '0;
      read_total_r     <= '0;
      read_position_r  <= '0;
      target_address_r <= '0;
      target_command_r <= '0;
    end else begin
      phase_r          <= phase_nxt;
      payload_fill_r   <= payload_fill_nxt;
      send_position_r  <= send_position_nxt;
      write_total_r    <= write_total_nxt;
      read_total_r     <= read_total_nxt;
      read_position_r  <= read_position_nxt;
      target_address_r <= target_address_nxt;
      target_command_r <= target_command_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_word_r <= res;
    end
  end

  // Next state and result
  always_comb begin
    phase_nxt          = phase_r;
    payload_fill_nxt   = payload_fill_r;
    send_position_nxt  = send_position_r;
    write_total_nxt    = write_total_r;
    read_total_nxt     = read_total_r;
    read_position_nxt  = read_position_r;
    target_address_nxt = target_address_r;
    target_command_nxt = target_command_r;
    mem_we             = 1'b0;
    res                = '0;
    res.bus_command    = BUS_NONE;

    if (in_accept) begin
      if (in_word.action != ACT_EVENT) begin
        if (phase_r != PH_IDLE) begin
          res.request_ignored = 1'b1;
        end else begin
          unique case (in_word.action)
            ACT_LOAD: begin
              if (32'(payload_fill_r) < 32'(BUFFER_DEPTH)) begin
                mem_we           = 1'b1;
                payload_fill_nxt = payload_fill_r + CNT_W'(1);
              end
            end
            ACT_WRITE: begin
              target_address_nxt = {in_word.slave_byte[7:1], 1'b0};
              target_command_nxt = in_word.command_byte;
              write_total_nxt    = (32'(in_word.byte_count) < 32'(BUFFER_DEPTH)) ?
                                   CNT_W'(in_word.byte_count) : CNT_W'(BUFFER_DEPTH);
              send_position_nxt  = '0;
              phase_nxt          = PH_W_ADDR;
              res.bus_command    = BUS_START;
            end
            ACT_READ: begin
              target_address_nxt = {in_word.slave_byte[7:1], 1'b0};
              target_command_nxt = in_word.command_byte;
              read_total_nxt     = (32'(read_count) < 32'(BUFFER_DEPTH)) ?
                                   CNT_W'(read_count) : CNT_W'(BUFFER_DEPTH);
              read_position_nxt  = '0;
              phase_nxt          = PH_R_ADDR;
              res.bus_command    = BUS_START;
            end
            default: ;
          endcase
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: ;
          PH_W_ADDR: begin
            if (!in_word.transmit_busy) begin
              res.bus_command   = BUS_TRANSMIT;
              res.transmit_byte = target_address_r;
              phase_nxt         = PH_W_CMD;
            end
          end
          PH_W_CMD: begin
            if (!in_word.transmit_busy) begin
              res.bus_command   = BUS_TRANSMIT;
              res.transmit_byte = target_command_r;
              phase_nxt         = PH_W_DATA;
            end
          end
          PH_W_DATA: begin
            if (!in_word.transmit_busy) begin
              if (send_position_r < write_total_r &&
                  32'(send_position_r) < 32'(BUFFER_DEPTH)) begin
                res.bus_command   = BUS_TRANSMIT;
                res.transmit_byte = mem_rdata_r;
                send_position_nxt = send_position_r + CNT_W'(1);
              end else begin
                res.bus_command   = BUS_STOP;
                payload_fill_nxt  = '0;
                send_position_nxt = '0;
                phase_nxt         = PH_IDLE;
              end
            end
          end
          PH_R_ADDR: begin
            res.bus_command   = BUS_TRANSMIT;
            res.transmit_byte = target_address_r;
            phase_nxt         = PH_R_REG;
          end
          PH_R_REG: begin
            res.bus_command   = BUS_TRANSMIT;
            res.transmit_byte = target_command_r;
            phase_nxt         = PH_R_RESTART;
          end
          PH_R_RESTART: begin
            res.bus_command = BUS_RESTART;
            phase_nxt       = PH_R_ADDR_RD;
          end
          PH_R_ADDR_RD: begin
            res.bus_command   = BUS_TRANSMIT;
            res.transmit_byte = {target_address_r[7:1], 1'b1};
            phase_nxt         = PH_R_ENABLE;
          end
          PH_R_ENABLE: begin
            res.bus_command = BUS_RX_ENABLE;
            phase_nxt       = PH_R_WAIT;
          end
          PH_R_WAIT: begin
            if (in_word.receive_full) begin
              res.read_valid = 1'b1;
              res.read_data  = in_word.received_byte;
              if (read_position_r + CNT_W'(1) < read_total_r) begin
                res.bus_command   = BUS_ACK;
                read_position_nxt = read_position_r + CNT_W'(1);
                phase_nxt         = PH_R_ENABLE;
              end else begin
                res.bus_command   = BUS_NACK_STOP;
                res.read_last     = 1'b1;
                read_position_nxt = '0;
                phase_nxt         = PH_IDLE;
              end
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
      res.busy_res = (phase_nxt != PH_IDLE);
    end
  end

  // Checks
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.read_last |->
      out_word_r.bus_command == BUS_NACK_STOP && !out_word_r.busy_res)
    else $error("last read byte without nack/stop or still busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(payload_fill_r) <= 32'(BUFFER_DEPTH))
    else $error("payload fill beyond buffer depth");

  a_read_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_R_WAIT || phase_r == PH_R_ENABLE) |-> read_position_r < read_total_r)
    else $error("read position past read length");

  a_load_counts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_word.action == ACT_LOAD && phase_r == PH_IDLE &&
    32'(payload_fill_r) < 32'(BUFFER_DEPTH) |=>
      payload_fill_r == $past(payload_fill_r) + CNT_W'(1))
    else $error("payload load not counted");

endmodule
